// ----- sv/vpic_pkg.sv -----
// shared types, register offsets and helpers for the interrupt controller
`default_nettype none
package vpic_pkg;

  localparam int SRC_COUNT = 128;
  localparam int NEST_LEVELS = 8;
  localparam int LANES = 8;
  localparam int ROWS = 128 / LANES;
  localparam int ROW_W = $clog2(ROWS);
  localparam int LANE_W = $clog2(LANES);
  localparam int SRC_W = 7;
  localparam int DEPTH_W = $clog2(NEST_LEVELS) + 1;

  localparam logic [SRC_W-1:0] WIN_MASK = 7'h7f;
  localparam logic [6:0] MODE_MASK = 7'h67;
  localparam logic [31:0] KEY_VALUE = 32'h41494300;
  localparam logic [31:0] KEY_MASK = 32'hffffff00;

  localparam logic [1:0] FN_READ = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_LINE = 2'd2;

  localparam logic [7:0] OFF_SSR = 8'h00;
  localparam logic [7:0] OFF_SMR = 8'h04;
  localparam logic [7:0] OFF_SVR = 8'h08;
  localparam logic [7:0] OFF_IVR = 8'h10;
  localparam logic [7:0] OFF_FVR = 8'h14;
  localparam logic [7:0] OFF_ISR = 8'h18;
  localparam logic [7:0] OFF_IPR0 = 8'h20;
  localparam logic [7:0] OFF_IPR1 = 8'h24;
  localparam logic [7:0] OFF_IPR2 = 8'h28;
  localparam logic [7:0] OFF_IPR3 = 8'h2c;
  localparam logic [7:0] OFF_IMR = 8'h30;
  localparam logic [7:0] OFF_CISR = 8'h34;
  localparam logic [7:0] OFF_EOICR = 8'h38;
  localparam logic [7:0] OFF_SPU = 8'h3c;
  localparam logic [7:0] OFF_IECR = 8'h40;
  localparam logic [7:0] OFF_IDCR = 8'h44;
  localparam logic [7:0] OFF_ICCR = 8'h48;
  localparam logic [7:0] OFF_ISCR = 8'h4c;
  localparam logic [7:0] OFF_FFER = 8'h50;
  localparam logic [7:0] OFF_FFDR = 8'h54;
  localparam logic [7:0] OFF_FFSR = 8'h58;
  localparam logic [7:0] OFF_SVRRER = 8'h60;
  localparam logic [7:0] OFF_SVRRDR = 8'h64;
  localparam logic [7:0] OFF_SVRRSR = 8'h68;
  localparam logic [7:0] OFF_DCR = 8'h6c;
  localparam logic [7:0] OFF_WPMR = 8'he4;
  localparam logic [7:0] OFF_WPSR = 8'he8;

  typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_MOD, ST_SCAN} st_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_offset;
    logic [31:0] write_data;
    logic [6:0] line_index;
    logic line_level;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic irq_out;
    logic fiq_out;
  } out_t;

  // per-source flags as kept in the flag memory
  typedef struct packed {
    logic ir;
    logic ff;
    logic en;
    logic edg;
    logic line;
    logic [1:0] typ;
    logic [2:0] prio;
  } src_t;

  typedef src_t [LANES-1:0] row_t;

  function automatic logic is_pending(src_t e, logic ext);
    logic p;
    if (e.typ[0]) begin
      p = e.edg;
    end else if (ext && e.typ == 2'd0) begin
      p = !e.line;
    end else begin
      p = e.line;
    end
    return p;
  endfunction

  // reset contents of a flag row: external lines idle high
  function automatic row_t row_init(logic [ROW_W-1:0] r);
    row_t v;
    v = '0;
    if (r == ROW_W'(0)) begin
      v[0].line = 1'b1;
    end
    if (r == ROW_W'(31 / LANES)) begin
      v[31 % LANES].line = 1'b1;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/vectored_priority_interrupt_controller.sv -----
// vectored priority interrupt controller: bus window, priority stack and request outputs
// each word passes through access, modify and the scan of the 16-row source flag memory,
// which re-evaluates the best pending source and the fast request after every word;
// a new word is taken only after the scan and while no result is held by rsp_stall
// reset: synchronous, clears control registers and the row and vector valid bits;
// unwritten memory entries read as their reset values, so no clearing pass is needed
`default_nettype none
module vectored_priority_interrupt_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire vpic_pkg::in_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output vpic_pkg::out_t      rsp
);
  import vpic_pkg::*;

  st_t state, state_next;
  in_t item;
  logic [ROW_W:0] scan_cnt;

  logic [SRC_W-1:0] window, window_next;
  logic [1:0] dbg, dbg_next;
  logic prot_en, prot_en_next;
  logic [15:0] prot_viol, prot_viol_next;
  logic [31:0] spur, spur_next;
  logic dvalid, dvalid_next;
  logic [SRC_W-1:0] dsrc, dsrc_next;
  logic [SRC_W-1:0] nest_src [NEST_LEVELS];
  logic [2:0] nest_pri [NEST_LEVELS];
  logic [DEPTH_W-1:0] depth;
  logic cand_valid;
  logic [SRC_W-1:0] cand_src;
  logic fiq_pend;
  logic [3:0] sc_lvl, sc_lvl_next;
  logic [SRC_W-1:0] sc_src, sc_src_next;
  logic sc_found, sc_found_next;
  logic sc_fiq, sc_fiq_next;
  logic [31:0] rd, rd_scan;
  logic out_valid;
  out_t out_word;

  // memories
  row_t fmem [ROWS];
  logic [ROWS-1:0] fvalid;
  row_t frow_q;
  logic fv_q;
  logic [ROW_W-1:0] fraddr_q;
  logic [31:0] vmem [SRC_COUNT];
  logic [SRC_COUNT-1:0] vvalid;
  logic [31:0] vraw_q;
  logic vv_q;

  logic f_re, f_we, v_re, v_we;
  logic [ROW_W-1:0] f_raddr, f_waddr;
  row_t f_wdata;

  logic [SRC_W-1:0] tsrc;
  row_t row_eff;
  logic [31:0] vdata;
  src_t e, e_new;
  logic wb, do_ack, pop, svr_wr;
  logic [31:0] rd_v;
  logic ok_w, ok_t, ext_t, prot_hit, bit0, is_ipr;
  logic [DEPTH_W-1:0] depth_m1;

  assign req_stall = (state != ST_IDLE) || (out_valid && rsp_stall);
  assign rsp_valid = out_valid;
  assign rsp = out_word;

  assign ok_w = {1'b0, window} < 8'(SRC_COUNT);
  assign ok_t = {1'b0, tsrc} < 8'(SRC_COUNT);
  assign ext_t = (tsrc == SRC_W'(0)) || (tsrc == SRC_W'(31));
  assign bit0 = item.write_data[0];
  assign depth_m1 = depth - DEPTH_W'(1);
  assign prot_hit = prot_en && (item.reg_offset == OFF_SMR || item.reg_offset == OFF_SVR ||
                                item.reg_offset == OFF_SPU || item.reg_offset == OFF_DCR);
  assign is_ipr = (item.func == FN_READ) && (item.reg_offset == OFF_IPR0 ||
                  item.reg_offset == OFF_IPR1 || item.reg_offset == OFF_IPR2 ||
                  item.reg_offset == OFF_IPR3);

  assign row_eff = fv_q ? frow_q : row_init(fraddr_q);
  assign vdata = vv_q ? vraw_q : 32'd0;
  assign e = row_eff[tsrc[LANE_W-1:0]];

  // source addressed by the current word
  always_comb begin
    tsrc = window;
    case (item.func)
      FN_LINE: tsrc = item.line_index;
      FN_READ: begin
        if (item.reg_offset == OFF_IVR) begin
          tsrc = cand_src;
        end else if (item.reg_offset == OFF_FVR) begin
          tsrc = '0;
        end
      end
      FN_WRITE: begin
        if (item.reg_offset == OFF_IVR) begin
          tsrc = dsrc;
        end
      end
      default: tsrc = window;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid && !req_stall) state_next = ST_ACC;
      ST_ACC: state_next = ST_MOD;
      ST_MOD: state_next = ST_SCAN;
      ST_SCAN: if (scan_cnt == (ROW_W+1)'(ROWS)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    f_re = 1'b0;
    f_raddr = tsrc[SRC_W-1:LANE_W];
    v_re = 1'b0;
    f_we = 1'b0;
    v_we = 1'b0;
    f_waddr = tsrc[SRC_W-1:LANE_W];
    f_wdata = row_eff;
    f_wdata[tsrc[LANE_W-1:0]] = e_new;
    case (state)
      ST_ACC: begin
        f_re = 1'b1;
        v_re = 1'b1;
      end
      ST_MOD: begin
        f_we = wb;
        v_we = svr_wr;
      end
      ST_SCAN: begin
        f_re = scan_cnt < (ROW_W+1)'(ROWS);
        f_raddr = scan_cnt[ROW_W-1:0];
      end
      default: f_re = 1'b0;
    endcase
  end

  // read-modify of the addressed source and the control registers
  always_comb begin
    e_new = e;
    wb = 1'b0;
    do_ack = 1'b0;
    pop = 1'b0;
    svr_wr = 1'b0;
    rd_v = '0;
    window_next = window;
    dbg_next = dbg;
    prot_en_next = prot_en;
    prot_viol_next = prot_viol;
    spur_next = spur;
    dvalid_next = dvalid;
    dsrc_next = dsrc;
    case (item.func)
      FN_READ: begin
        case (item.reg_offset)
          OFF_SSR: rd_v = 32'(window);
          OFF_SMR: rd_v = ok_w ? {25'd0, e.typ, 2'b00, e.prio} : 32'd0;
          OFF_SVR: rd_v = ok_w ? vdata : 32'd0;
          OFF_IVR: begin
            if (!cand_valid) begin
              rd_v = spur;
            end else if (e.ir) begin
              rd_v = 32'(cand_src);
            end else begin
              rd_v = vdata;
            end
            if (dbg[0]) begin
              dvalid_next = cand_valid;
              dsrc_next = cand_valid ? cand_src : '0;
            end else begin
              do_ack = cand_valid;
            end
          end
          OFF_FVR: begin
            if (!fiq_pend) begin
              rd_v = spur;
            end else begin
              rd_v = vdata;
              if (e.en && is_pending(e, 1'b1) && e.typ[0]) begin
                e_new.edg = 1'b0;
                wb = 1'b1;
              end
            end
          end
          OFF_ISR: rd_v = (depth != '0) ? 32'(nest_src[depth_m1[DEPTH_W-2:0]]) : 32'd0;
          OFF_IMR: rd_v = 32'(ok_w && e.en);
          OFF_CISR: rd_v = dbg[1] ? 32'd0 : {30'd0, cand_valid, fiq_pend};
          OFF_SPU: rd_v = spur;
          OFF_FFSR: rd_v = 32'(ok_w && e.ff);
          OFF_SVRRSR: rd_v = 32'(ok_w && e.ir);
          OFF_DCR: rd_v = 32'(dbg);
          OFF_WPMR: rd_v = 32'(prot_en);
          OFF_WPSR: begin
            rd_v = 32'(prot_viol);
            prot_viol_next = '0;
          end
          default: rd_v = '0;
        endcase
      end
      FN_WRITE: begin
        if (prot_hit) begin
          prot_viol_next = {item.reg_offset, 8'h01};
        end else begin
          case (item.reg_offset)
            OFF_SSR: window_next = item.write_data[SRC_W-1:0] & WIN_MASK;
            OFF_SMR: begin
              if (ok_w) begin
                e_new.prio = item.write_data[2:0] & MODE_MASK[2:0];
                e_new.typ = item.write_data[6:5] & MODE_MASK[6:5];
                wb = 1'b1;
              end
            end
            OFF_SVR: svr_wr = ok_w;
            OFF_IVR: begin
              if (dbg[0]) begin
                dvalid_next = 1'b0;
                do_ack = dvalid;
              end
            end
            OFF_EOICR: pop = depth != '0;
            OFF_SPU: spur_next = item.write_data;
            OFF_IECR: if (ok_w && bit0) begin e_new.en = 1'b1; wb = 1'b1; end
            OFF_IDCR: if (ok_w && bit0) begin e_new.en = 1'b0; wb = 1'b1; end
            OFF_ICCR: if (ok_w && bit0 && e.typ[0]) begin e_new.edg = 1'b0; wb = 1'b1; end
            OFF_ISCR: if (ok_w && bit0 && e.typ[0]) begin e_new.edg = 1'b1; wb = 1'b1; end
            OFF_FFER: if (ok_w && bit0) begin e_new.ff = 1'b1; wb = 1'b1; end
            OFF_FFDR: if (ok_w && bit0) begin e_new.ff = 1'b0; wb = 1'b1; end
            OFF_SVRRER: if (ok_w && bit0) begin e_new.ir = 1'b1; wb = 1'b1; end
            OFF_SVRRDR: if (ok_w && bit0) begin e_new.ir = 1'b0; wb = 1'b1; end
            OFF_DCR: begin
              dbg_next = item.write_data[1:0];
              if (!item.write_data[0]) begin
                dvalid_next = 1'b0;
                dsrc_next = '0;
              end
            end
            OFF_WPMR: begin
              if ((item.write_data & KEY_MASK) == KEY_VALUE) begin
                prot_en_next = item.write_data[0];
              end
            end
            default: wb = 1'b0;
          endcase
        end
      end
      FN_LINE: begin
        if (ok_t && e.line != item.line_level) begin
          e_new.line = item.line_level;
          wb = 1'b1;
          if (e.typ[0]) begin
            // falling edge only for external sources in type one
            if (ext_t && e.typ == 2'd1) begin
              e_new.edg = e.edg | (e.line && !item.line_level);
            end else begin
              e_new.edg = e.edg | (!e.line && item.line_level);
            end
          end
        end
      end
      default: wb = 1'b0;
    endcase
    if (do_ack && ok_t && e.typ[0]) begin
      e_new.edg = 1'b0;
      wb = 1'b1;
    end
  end

  // one flag row per scan cycle: best pending source, fast request and the pending bits of an IPR read
  always_comb begin
    logic [ROW_W-1:0] prow;
    logic [SRC_W-1:0] s;
    logic p;
    sc_lvl_next = sc_lvl;
    sc_src_next = sc_src;
    sc_found_next = sc_found;
    sc_fiq_next = sc_fiq;
    rd_scan = rd;
    prow = scan_cnt[ROW_W-1:0] - ROW_W'(1);
    for (int l = 0; l < LANES; l++) begin
      s = {prow, LANE_W'(l)};
      p = is_pending(row_eff[l], (s == SRC_W'(0)) || (s == SRC_W'(31)));
      if ({1'b0, s} < 8'(SRC_COUNT)) begin
        if (s != SRC_W'(0) && row_eff[l].en && !row_eff[l].ff && p &&
            {1'b0, row_eff[l].prio} + 4'd1 > sc_lvl_next) begin
          sc_lvl_next = {1'b0, row_eff[l].prio} + 4'd1;
          sc_src_next = s;
          sc_found_next = 1'b1;
        end
        if (row_eff[l].en && p && (s == SRC_W'(0) || row_eff[l].ff)) begin
          sc_fiq_next = 1'b1;
        end
        if (is_ipr && prow[ROW_W-1:ROW_W-2] == item.reg_offset[3:2]) begin
          rd_scan[{prow[1:0], LANE_W'(l)}] = p;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    if (f_re) begin
      frow_q <= fmem[f_raddr];
      fv_q <= fvalid[f_raddr];
      fraddr_q <= f_raddr;
    end
    if (v_we) begin
      vmem[window] <= item.write_data;
    end
    if (v_re) begin
      vraw_q <= vmem[tsrc];
      vv_q <= vvalid[tsrc];
    end
    if (rst) begin
      fvalid <= '0;
      vvalid <= '0;
    end else begin
      if (f_we) fvalid[f_waddr] <= 1'b1;
      if (v_we) vvalid[window] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan_cnt <= '0;
      window <= '0;
      dbg <= '0;
      prot_en <= 1'b0;
      prot_viol <= '0;
      spur <= '0;
      dvalid <= 1'b0;
      dsrc <= '0;
      depth <= '0;
      cand_valid <= 1'b0;
      cand_src <= '0;
      fiq_pend <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NEST_LEVELS; i++) begin
        nest_src[i] <= '0;
        nest_pri[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_valid && !rsp_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid && !req_stall) begin
            item <= req;
          end
        end
        ST_MOD: begin
          window <= window_next;
          dbg <= dbg_next;
          prot_en <= prot_en_next;
          prot_viol <= prot_viol_next;
          spur <= spur_next;
          dvalid <= dvalid_next;
          dsrc <= dsrc_next;
          rd <= rd_v;
          if (do_ack && ok_t && depth < DEPTH_W'(NEST_LEVELS)) begin
            nest_src[depth[DEPTH_W-2:0]] <= tsrc;
            nest_pri[depth[DEPTH_W-2:0]] <= e.prio;
            depth <= depth + DEPTH_W'(1);
          end else if (pop) begin
            depth <= depth_m1;
          end
          scan_cnt <= '0;
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + (ROW_W+1)'(1);
          if (scan_cnt == '0) begin
            sc_lvl <= (depth != '0) ? {1'b0, nest_pri[depth_m1[DEPTH_W-2:0]]} + 4'd1 : 4'd0;
            sc_src <= '0;
            sc_found <= 1'b0;
            sc_fiq <= 1'b0;
          end else begin
            sc_lvl <= sc_lvl_next;
            sc_src <= sc_src_next;
            sc_found <= sc_found_next;
            sc_fiq <= sc_fiq_next;
            rd <= rd_scan;
          end
          if (scan_cnt == (ROW_W+1)'(ROWS)) begin
            cand_valid <= sc_found_next;
            cand_src <= sc_src_next;
            fiq_pend <= sc_fiq_next;
            out_valid <= 1'b1;
            out_word.read_data <= rd_scan;
            out_word.irq_out <= sc_found_next && !dbg[1];
            out_word.fiq_out <= sc_fiq_next && !dbg[1];
          end
        end
        default: scan_cnt <= scan_cnt;
      endcase
    end
  end

endmodule
`default_nettype wire
